[rtl/ekvt_pkg.sv]
// Shared types, codes and constants for the knob value tracker.
`timescale 1ns / 1ps

package ekvt_pkg;

    localparam int NUM_CHANNELS = 4;
    localparam int ADDR_SHIFT   = 4;

    localparam int CH_W      = 2;
    localparam int VAL_W     = 7;
    localparam int ADDR_W    = 8;
    localparam int NIB_W     = 4;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 7;
    localparam int MEM_DEPTH = 2 ** CH_W;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;
    localparam int FIFO_CW    = 3;

    localparam logic [VAL_W-1:0] FULL_SCALE = 7'd127;

    localparam logic [1:0] MODE_STEP_A = 2'd0;
    localparam logic [1:0] MODE_STEP_B = 2'd1;
    localparam logic [1:0] MODE_TOGGLE = 2'd2;
    localparam logic [1:0] MODE_NOTE   = 2'd3;

    localparam logic [1:0] ROT_NONE = 2'd0;
    localparam logic [1:0] ROT_CW   = 2'd1;
    localparam logic [1:0] ROT_CCW  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_MODE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_A = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_B = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BASE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_NOTE   = 3'd4;

    typedef struct packed {
        logic [1:0]       mode;
        logic [VAL_W-1:0] step_a;
        logic [VAL_W-1:0] step_b;
        logic [NIB_W-1:0] base_address;
        logic [NIB_W-1:0] note_address;
    } t_cfg;

    typedef struct packed {
        logic [VAL_W-1:0] value;
        logic             last_button;
        logic             toggle;
    } t_knob_state;

    typedef struct packed {
        logic [ADDR_W-1:0] address;
        logic [VAL_W-1:0]  value;
        logic              last;
    } t_result;

endpackage

[rtl/ekvt_step.sv]
// Per-word update of one channel's knob state and the reports it causes.
`timescale 1ns / 1ps

module ekvt_step
    import ekvt_pkg::*;
(
    input  t_cfg             i_cfg,
    input  logic [CH_W-1:0]  i_channel,
    input  logic             i_button,
    input  logic [1:0]       i_rotation,
    input  t_knob_state      i_state,
    output t_knob_state      o_state,
    output logic [1:0]       o_count,
    output t_result          o_res0,
    output t_result          o_res1
);

    logic              w_changed;
    logic              w_step_mode;
    logic              w_btn_rep;
    logic              w_rot_rep;
    logic [VAL_W-1:0]  w_val_btn;
    logic              w_tog_btn;
    logic [VAL_W-1:0]  w_btn_val;
    logic [VAL_W-1:0]  w_delta;
    logic [VAL_W:0]    w_sum;
    logic [VAL_W-1:0]  w_val_rot;
    logic [ADDR_W-1:0] w_ch_off;
    logic [ADDR_W-1:0] w_base_addr;
    logic [ADDR_W-1:0] w_note_addr;
    t_result           w_btn_res;
    t_result           w_rot_res;

    assign w_changed   = (i_button != i_state.last_button);
    assign w_step_mode = (i_cfg.mode == MODE_STEP_A) || (i_cfg.mode == MODE_STEP_B);
    assign w_ch_off    = ADDR_W'(i_channel) << ADDR_SHIFT;
    assign w_base_addr = ADDR_W'(i_cfg.base_address) + w_ch_off;
    assign w_note_addr = ADDR_W'(i_cfg.note_address) + w_ch_off;

    // button first
    always_comb begin
        w_val_btn = i_state.value;
        w_tog_btn = i_state.toggle;
        w_btn_rep = 1'b0;
        w_btn_val = '0;
        if (w_changed) begin
            if (i_cfg.mode == MODE_NOTE) begin
                w_btn_rep = 1'b1;
                w_btn_val = i_button ? FULL_SCALE : '0;
            end else if (i_cfg.mode == MODE_TOGGLE && i_button) begin
                w_btn_rep = 1'b1;
                w_tog_btn = ~i_state.toggle;
                w_val_btn = w_tog_btn ? FULL_SCALE : '0;
                w_btn_val = w_val_btn;
            end
        end
    end

    // then rotation, saturating at both ends
    always_comb begin
        w_delta = 7'd1;
        if (w_step_mode && i_button) begin
            w_delta = (i_cfg.mode == MODE_STEP_A) ? i_cfg.step_a : i_cfg.step_b;
        end
        w_sum     = {1'b0, w_val_btn} + {1'b0, w_delta};
        w_val_rot = w_val_btn;
        w_rot_rep = 1'b0;
        case (i_rotation)
            ROT_CW: begin
                if (w_val_btn != FULL_SCALE) begin
                    w_rot_rep = 1'b1;
                    w_val_rot = w_sum[VAL_W] ? FULL_SCALE : w_sum[VAL_W-1:0];
                end
            end
            ROT_CCW: begin
                if (w_val_btn != '0) begin
                    w_rot_rep = 1'b1;
                    w_val_rot = (w_delta >= w_val_btn) ? '0 : w_val_btn - w_delta;
                end
            end
            default: begin
                w_rot_rep = 1'b0;
            end
        endcase
    end

    assign w_btn_res.address = (i_cfg.mode == MODE_NOTE) ? w_note_addr : w_base_addr;
    assign w_btn_res.value   = w_btn_val;
    assign w_btn_res.last    = ~w_rot_rep;
    assign w_rot_res.address = w_base_addr;
    assign w_rot_res.value   = w_val_rot;
    assign w_rot_res.last    = 1'b1;

    assign o_state.value       = w_val_rot;
    assign o_state.last_button = i_button;
    assign o_state.toggle      = w_tog_btn;

    assign o_count = {1'b0, w_btn_rep} + {1'b0, w_rot_rep};
    assign o_res0  = w_btn_rep ? w_btn_res : w_rot_res;
    assign o_res1  = w_rot_res;

endmodule

[rtl/ekvt_fifo.sv]
// Four-word report queue taking up to two words per cycle.
`timescale 1ns / 1ps

module ekvt_fifo
    import ekvt_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [1:0]         i_push_count,
    input  t_result            i_d0,
    input  t_result            i_d1,
    input  logic               i_pop,
    output t_result            o_head,
    output logic               o_valid,
    output logic [FIFO_CW-1:0] o_count
);

    t_result              r_q [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   r_wptr;
    logic [FIFO_AW-1:0]   r_rptr;
    logic [FIFO_CW-1:0]   r_count;
    logic [FIFO_AW-1:0]   w_wptr1;

    assign w_wptr1 = r_wptr + 1'b1;

    always_ff @(posedge i_clk) begin
        if (i_push_count != 2'd0) begin
            r_q[r_wptr] <= i_d0;
        end
        if (i_push_count == 2'd2) begin
            r_q[w_wptr1] <= i_d1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= r_wptr + FIFO_AW'(i_push_count);
            r_rptr  <= r_rptr + FIFO_AW'(i_pop);
            r_count <= r_count + FIFO_CW'(i_push_count) - FIFO_CW'(i_pop);
        end
    end

    assign o_head  = r_q[r_rptr];
    assign o_valid = (r_count != '0);
    assign o_count = r_count;

endmodule

[rtl/encoder_knob_value_tracker.sv]
// Top level of the knob value tracker: state memory, update stage and report queue.
`timescale 1ns / 1ps
//
// Channel    | Dir | Fields (low bit up)                          | Handshake
// -----------+-----+----------------------------------------------+------------------
// s_axis     | in  | tdata: channel[1:0] button[2] rotation[4:3]  | tvalid/tready
// m_axis     | out | tdata: address[7:0] value[14:8]; tlast       | tvalid/tready
// cfg        | in  | index[2:0], data[6:0]                        | valid/ready
//
// An input word is read from the state memory in its accept cycle and updated
// in the following cycle, when up to two report words enter a four-word queue.
// Words with one report or none flow at one per cycle; words with two reports
// cannot keep that rate, as the output port carries one word per cycle.
// Back-to-back words on one channel take the just-written state from a bypass.
// Synchronous active-low reset clears valid bits and queue and loads config
// defaults; stalls on m_axis back up through the queue and drop s_axis tready.
module encoder_knob_value_tracker
    import ekvt_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // s_axis tdata: channel[1:0], button_pressed[2], rotation[4:3], zero pad
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    input  logic [7:0]           i_s_axis_tdata,
    // m_axis tdata: message_address[7:0], message_value[14:8], zero pad
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    output logic [15:0]          o_m_axis_tdata,
    output logic                 o_m_axis_tlast,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data
);

    t_cfg               r_cfg;

    // state memory, one entry per channel, valid bits stand in for the clear
    t_knob_state        r_mem [MEM_DEPTH];
    logic [MEM_DEPTH-1:0] r_vld;

    logic [CH_W-1:0]    w_in_ch;
    logic               w_in_btn;
    logic [1:0]         w_in_rot;
    logic               w_accept;
    logic               w_in_range;

    logic               r_s1_valid;
    logic [CH_W-1:0]    r_s1_ch;
    logic               r_s1_btn;
    logic [1:0]         r_s1_rot;
    t_knob_state        r_rd_data;
    logic               r_rd_vld;

    // bypass of the previous cycle's write-back
    logic               r_fwd_valid;
    logic [CH_W-1:0]    r_fwd_ch;
    t_knob_state        r_fwd_data;

    t_knob_state        w_cur_state;
    t_knob_state        w_new_state;
    logic [1:0]         w_res_count;
    logic [1:0]         w_push_count;
    t_result            w_res0;
    t_result            w_res1;
    t_result            w_head;
    logic               w_head_valid;
    logic               w_pop;
    logic [FIFO_CW-1:0] w_fifo_count;

    assign w_in_ch    = i_s_axis_tdata[1:0];
    assign w_in_btn   = i_s_axis_tdata[2];
    assign w_in_rot   = i_s_axis_tdata[4:3];
    assign w_in_range = (32'(w_in_ch) < NUM_CHANNELS);

    // room for two words from this item once the update stage has pushed its own
    assign o_s_axis_tready = ((w_fifo_count + 3'(w_push_count)) <= 3'd2);
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;

    // config
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode         <= MODE_STEP_A;
            r_cfg.step_a       <= 7'd8;
            r_cfg.step_b       <= 7'd16;
            r_cfg.base_address <= 4'd0;
            r_cfg.note_address <= 4'd1;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_MODE:   r_cfg.mode         <= i_cfg_data[1:0];
                REG_STEP_A: r_cfg.step_a       <= i_cfg_data;
                REG_STEP_B: r_cfg.step_b       <= i_cfg_data;
                REG_BASE:   r_cfg.base_address <= i_cfg_data[NIB_W-1:0];
                REG_NOTE:   r_cfg.note_address <= i_cfg_data[NIB_W-1:0];
                default:    r_cfg              <= r_cfg;
            endcase
        end
    end

    // read stage
    always_ff @(posedge i_clk) begin
        r_s1_ch   <= w_in_ch;
        r_s1_btn  <= w_in_btn;
        r_s1_rot  <= w_in_rot;
        r_rd_data <= r_mem[w_in_ch];
        r_rd_vld  <= r_vld[w_in_ch];
    end

    // update stage and write-back
    assign w_cur_state = (r_fwd_valid && (r_fwd_ch == r_s1_ch)) ? r_fwd_data :
                         (r_rd_vld ? r_rd_data : '0);

    ekvt_step u_step (
        .i_cfg      (r_cfg),
        .i_channel  (r_s1_ch),
        .i_button   (r_s1_btn),
        .i_rotation (r_s1_rot),
        .i_state    (w_cur_state),
        .o_state    (w_new_state),
        .o_count    (w_res_count),
        .o_res0     (w_res0),
        .o_res1     (w_res1)
    );

    assign w_push_count = r_s1_valid ? w_res_count : 2'd0;

    always_ff @(posedge i_clk) begin
        if (r_s1_valid) begin
            r_mem[r_s1_ch] <= w_new_state;
        end
        r_fwd_ch   <= r_s1_ch;
        r_fwd_data <= w_new_state;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_fwd_valid <= 1'b0;
            r_vld       <= '0;
        end else begin
            r_s1_valid  <= w_accept && w_in_range;
            r_fwd_valid <= r_s1_valid;
            if (r_s1_valid) begin
                r_vld[r_s1_ch] <= 1'b1;
            end
        end
    end

    // output queue
    assign w_pop = w_head_valid && i_m_axis_tready;

    ekvt_fifo u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_count (w_push_count),
        .i_d0         (w_res0),
        .i_d1         (w_res1),
        .i_pop        (w_pop),
        .o_head       (w_head),
        .o_valid      (w_head_valid),
        .o_count      (w_fifo_count)
    );

    assign o_m_axis_tvalid = w_head_valid;
    assign o_m_axis_tdata  = {1'b0, w_head.value, w_head.address};
    assign o_m_axis_tlast  = w_head.last;

`ifndef SYNTH
    a_fifo_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fifo_count <= 3'(FIFO_DEPTH)))
        else $error("report queue over-filled");

    a_push_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid |-> ((w_fifo_count + 3'(w_push_count)) <= 3'(FIFO_DEPTH)))
        else $error("update stage pushed into a full queue");

    a_two_need_button: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && (w_push_count == 2'd2)) |->
            ((r_cfg.mode == MODE_TOGGLE) || (r_cfg.mode == MODE_NOTE)))
        else $error("two reports in a step mode");
`endif

endmodule
